// ===== rtl/plc_fbs_pkg.sv =====
// shared types and constants of the function block scan engine
// field widths, request and block kind codes, table entry and block state
// no dependencies
package plc_fbs_pkg;

    localparam int REQ_W     = 2;
    localparam int IDX_W     = 6;
    localparam int KIND_W    = 3;
    localparam int SRC_W     = 8;
    localparam int RES_W     = 8;
    localparam int TIME_W    = 32;
    localparam int IO_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;
    localparam int CNT_W     = 7;
    localparam int CH_CNT_W  = 5;

    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int DEF_NUM_INPUTS  = 16;
    localparam int DEF_NUM_OUTPUTS = 16;

    localparam logic [CNT_W-1:0]    BLOCK_COUNT_RST  = 7'd0;
    localparam logic [CH_CNT_W-1:0] INPUT_COUNT_RST  = 5'd16;
    localparam logic [CH_CNT_W-1:0] OUTPUT_COUNT_RST = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_COUNT  = 2'd0,
        CFG_INPUT_COUNT  = 2'd1,
        CFG_OUTPUT_COUNT = 2'd2
    } t_cfg_reg;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_SCAN  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [KIND_W-1:0] {
        KIND_INPUT     = 3'd0,
        KIND_OUTPUT    = 3'd1,
        KIND_NOT       = 3'd2,
        KIND_AND       = 3'd3,
        KIND_OR        = 3'd4,
        KIND_SET_RESET = 3'd5,
        KIND_ON_DELAY  = 3'd6
    } t_kind;

    // one program table entry, 59 bits
    typedef struct packed {
        t_kind             kind;
        logic [SRC_W-1:0]  src_a;
        logic [SRC_W-1:0]  src_b;
        logic [RES_W-1:0]  res;
        logic [TIME_W-1:0] delay;
    } t_entry;

    // per block run state
    typedef struct packed {
        logic              value;
        logic              running;
        logic [TIME_W-1:0] start;
    } t_bstate;

endpackage

// ===== rtl/plc_function_block_scan_top.sv =====
// function block scan engine: program table, block state memory, scan sequencer
// depends on plc_fbs_pkg
//
// usage
//   one input channel (i_in_valid / o_in_ready) carries request words: write a
//   block entry, run one scan, or read one block value. one output channel
//   (o_out_valid / i_out_ready) returns exactly one result word per request
//   with the held output bits, an ok flag and the value read.
//   the configuration port (i_cfg_we, i_cfg_index, i_cfg_wdata) sets the
//   block count, input count and output count; write it only while idle.
// sequencing
//   a write or unknown request goes straight to the result stage; a read
//   request first passes an address state and a wait state
//   a scan walks the blocks in order after a fetch state; each block uses
//   the block state memory first for its own state and table fetch, then
//   for both source reads; output blocks are folded into the walk
//   one request is in work at a time; o_in_ready is high only when idle
// reset
//   synchronous, active low. block state reads as zero through per entry
//   valid bits cleared at once, so no clearing pass is needed; the program
//   table is undefined until written. held outputs clear to zero.
// stall
//   a finished word waits in the output register; the next request is taken
//   meanwhile and its result waits in the engine until the register frees
module plc_function_block_scan_top #(
    parameter int MAX_BLOCKS  = plc_fbs_pkg::DEF_MAX_BLOCKS,
    parameter int NUM_INPUTS  = plc_fbs_pkg::DEF_NUM_INPUTS,
    parameter int NUM_OUTPUTS = plc_fbs_pkg::DEF_NUM_OUTPUTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [plc_fbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [plc_fbs_pkg::CFG_W-1:0]       i_cfg_wdata,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [plc_fbs_pkg::REQ_W-1:0]       i_req_type,
    input  logic [plc_fbs_pkg::IDX_W-1:0]       i_block_index,
    input  logic [plc_fbs_pkg::KIND_W-1:0]      i_block_kind,
    input  logic [plc_fbs_pkg::SRC_W-1:0]       i_source_first,
    input  logic [plc_fbs_pkg::SRC_W-1:0]       i_source_second,
    input  logic [plc_fbs_pkg::RES_W-1:0]       i_io_resource,
    input  logic [plc_fbs_pkg::TIME_W-1:0]      i_delay_ms,
    input  logic [plc_fbs_pkg::TIME_W-1:0]      i_now_ms,
    input  logic [plc_fbs_pkg::IO_W-1:0]        i_input_bits,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [plc_fbs_pkg::IO_W-1:0]        o_output_bits,
    output logic                                o_scan_ok,
    output logic                                o_value_read
);

    localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int NW   = (CW > plc_fbs_pkg::SRC_W) ? CW : plc_fbs_pkg::SRC_W;
    localparam int ICAP = (NUM_INPUTS < plc_fbs_pkg::IO_W) ? NUM_INPUTS : plc_fbs_pkg::IO_W;
    localparam int OCAP = (NUM_OUTPUTS < plc_fbs_pkg::IO_W) ? NUM_OUTPUTS : plc_fbs_pkg::IO_W;
    localparam int CHW  = plc_fbs_pkg::CH_CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SRC,
        S_EXEC,
        S_RDADDR,
        S_RDWAIT,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [plc_fbs_pkg::CNT_W-1:0] r_block_count;
    logic [CHW-1:0]                r_input_count;
    logic [CHW-1:0]                r_output_count;

    // memories and their read registers
    plc_fbs_pkg::t_entry  r_table   [MAX_BLOCKS];
    plc_fbs_pkg::t_bstate r_bst_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_valid;
    plc_fbs_pkg::t_entry  r_tab_q;
    plc_fbs_pkg::t_bstate r_rd_a;
    plc_fbs_pkg::t_bstate r_rd_b;
    logic                 r_va_q;
    logic                 r_vb_q;

    // scan context
    logic [AW-1:0]                   r_blk;
    logic [plc_fbs_pkg::TIME_W-1:0]  r_now;
    logic [plc_fbs_pkg::IO_W-1:0]    r_in_bits;
    logic [plc_fbs_pkg::IO_W-1:0]    r_stage;
    logic [plc_fbs_pkg::IO_W-1:0]    r_held;
    logic                            r_fail;
    plc_fbs_pkg::t_bstate            r_own;

    // pending result
    logic [plc_fbs_pkg::IO_W-1:0]    r_res_bits;
    logic                            r_res_ok;
    logic                            r_res_val;

    logic          in_acc;
    logic [NW-1:0] n_eff;
    logic [CHW-1:0] ilim;
    logic [CHW-1:0] olim;
    logic          idx_ok;
    logic          tab_we;
    logic [AW-1:0] blk_next;
    logic [AW-1:0] addr_tab;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic          st_we;
    logic          last_blk;

    // evaluation of the current block
    logic                           src_a_val;
    logic                           src_b_val;
    logic                           ex_v;
    logic                           ex_run;
    logic [plc_fbs_pkg::TIME_W-1:0] ex_start;
    logic [plc_fbs_pkg::TIME_W-1:0] ex_elapsed;
    logic [plc_fbs_pkg::IO_W-1:0]   ex_stage;
    logic                           ex_bad;
    logic                           ex_ofail;
    logic                           fail_all;
    plc_fbs_pkg::t_bstate           st_wdata;

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign in_acc     = i_in_valid && o_in_ready;

    // limits after saturation to the built sizes
    assign n_eff = (NW'(r_block_count) > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS)
                                                          : NW'(r_block_count);
    assign ilim  = (r_input_count > CHW'(ICAP)) ? CHW'(ICAP) : r_input_count;
    assign olim  = (r_output_count > CHW'(OCAP)) ? CHW'(OCAP) : r_output_count;

    assign idx_ok   = NW'(i_block_index) < NW'(MAX_BLOCKS);
    assign tab_we   = in_acc && (i_req_type == plc_fbs_pkg::REQ_WRITE) && idx_ok;
    assign blk_next = r_blk + 1'b1;
    assign last_blk = NW'(r_blk) == (n_eff - NW'(1));

    // exec prefetches the next block while the current one is written back
    assign addr_tab = (r_state == S_EXEC) ? blk_next : r_blk;
    assign addr_a   = (r_state == S_SRC)  ? AW'(r_tab_q.src_a)
                    : (r_state == S_EXEC) ? blk_next : r_blk;
    assign addr_b   = AW'(r_tab_q.src_b);

    // sources at or past the block count read false
    assign src_a_val = (NW'(r_tab_q.src_a) < n_eff) && r_va_q && r_rd_a.value;
    assign src_b_val = (NW'(r_tab_q.src_b) < n_eff) && r_vb_q && r_rd_b.value;

    always_comb begin
        ex_v       = r_own.value;
        ex_run     = 1'b0;
        ex_start   = r_own.start;
        ex_elapsed = '0;
        ex_stage   = r_stage;
        ex_bad     = 1'b0;
        ex_ofail   = 1'b0;
        case (r_tab_q.kind)
            plc_fbs_pkg::KIND_INPUT: begin
                ex_v = (r_tab_q.res < 8'(ilim)) && r_in_bits[r_tab_q.res[3:0]];
            end
            plc_fbs_pkg::KIND_OUTPUT: begin
                ex_v = src_a_val;
                if (r_tab_q.res < 8'(olim)) begin
                    ex_stage[r_tab_q.res[3:0]] = src_a_val;
                end else begin
                    ex_ofail = 1'b1;
                end
            end
            plc_fbs_pkg::KIND_NOT: ex_v = !src_a_val;
            plc_fbs_pkg::KIND_AND: ex_v = src_a_val && src_b_val;
            plc_fbs_pkg::KIND_OR:  ex_v = src_a_val || src_b_val;
            plc_fbs_pkg::KIND_SET_RESET: begin
                // reset dominant
                if (src_b_val) begin
                    ex_v = 1'b0;
                end else if (src_a_val) begin
                    ex_v = 1'b1;
                end
            end
            plc_fbs_pkg::KIND_ON_DELAY: begin
                ex_run = r_own.running;
                if (!src_a_val) begin
                    ex_v     = 1'b0;
                    ex_run   = 1'b0;
                    ex_start = '0;
                end else if (!r_own.value) begin
                    if (!r_own.running) begin
                        ex_start = r_now;
                    end
                    ex_run     = 1'b1;
                    ex_elapsed = r_now - ex_start;
                    if (ex_elapsed >= r_tab_q.delay) begin
                        ex_v   = 1'b1;
                        ex_run = 1'b0;
                    end
                end
            end
            default: ex_bad = 1'b1;
        endcase
    end

    assign fail_all = r_fail || ex_ofail;
    assign st_we    = (r_state == S_EXEC) && !ex_bad;
    assign st_wdata = '{value: ex_v, running: ex_run, start: ex_start};

    // program table: written by requests, read by the scan
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_table[AW'(i_block_index)] <= '{
                kind:  plc_fbs_pkg::t_kind'(i_block_kind),
                src_a: i_source_first,
                src_b: i_source_second,
                res:   i_io_resource,
                delay: i_delay_ms
            };
        end
        r_tab_q <= r_table[addr_tab];
    end

    // block state memory, two read ports and one write port
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_bst_mem[r_blk] <= st_wdata;
        end
        r_rd_a <= r_bst_mem[addr_a];
        r_rd_b <= r_bst_mem[addr_b];
        r_va_q <= r_valid[addr_a];
        r_vb_q <= r_valid[addr_b];
    end

    // sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            o_out_valid    <= 1'b0;
            r_valid        <= '0;
            r_held         <= '0;
            r_block_count  <= plc_fbs_pkg::BLOCK_COUNT_RST;
            r_input_count  <= plc_fbs_pkg::INPUT_COUNT_RST;
            r_output_count <= plc_fbs_pkg::OUTPUT_COUNT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    plc_fbs_pkg::CFG_BLOCK_COUNT:  r_block_count  <= i_cfg_wdata;
                    plc_fbs_pkg::CFG_INPUT_COUNT:  r_input_count  <= i_cfg_wdata[CHW-1:0];
                    plc_fbs_pkg::CFG_OUTPUT_COUNT: r_output_count <= i_cfg_wdata[CHW-1:0];
                    default: ;
                endcase
            end

            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_now      <= i_now_ms;
                        r_in_bits  <= i_input_bits;
                        r_res_bits <= r_held;
                        r_res_val  <= 1'b0;
                        r_res_ok   <= 1'b0;
                        r_state    <= S_DONE;
                        case (i_req_type)
                            plc_fbs_pkg::REQ_WRITE: begin
                                // a new entry starts from cleared state
                                r_res_ok <= idx_ok;
                                if (idx_ok) begin
                                    r_valid[AW'(i_block_index)] <= 1'b0;
                                end
                            end
                            plc_fbs_pkg::REQ_SCAN: begin
                                if (n_eff == '0) begin
                                    r_held     <= '0;
                                    r_res_bits <= '0;
                                end else begin
                                    r_blk   <= '0;
                                    r_stage <= r_held;
                                    r_fail  <= 1'b0;
                                    r_state <= S_FETCH;
                                end
                            end
                            plc_fbs_pkg::REQ_READ: begin
                                if (NW'(i_block_index) < n_eff) begin
                                    r_blk   <= AW'(i_block_index);
                                    r_state <= S_RDADDR;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FETCH: r_state <= S_SRC;
                S_SRC: begin
                    // own state arrives here, sources are read now
                    r_own   <= r_va_q ? r_rd_a : '0;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (ex_bad) begin
                        // unknown kind stops the scan, earlier blocks keep values
                        r_held     <= '0;
                        r_res_bits <= '0;
                        r_res_ok   <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        r_valid[r_blk] <= 1'b1;
                        r_stage        <= ex_stage;
                        r_fail         <= fail_all;
                        if (last_blk) begin
                            r_held     <= fail_all ? '0 : ex_stage;
                            r_res_bits <= fail_all ? '0 : ex_stage;
                            r_res_ok   <= !fail_all;
                            r_state    <= S_DONE;
                        end else begin
                            r_blk   <= blk_next;
                            r_state <= S_SRC;
                        end
                    end
                end
                S_RDADDR: r_state <= S_RDWAIT;
                S_RDWAIT: begin
                    r_res_ok  <= 1'b1;
                    r_res_val <= r_va_q && r_rd_a.value;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid   <= 1'b1;
                        o_output_bits <= r_res_bits;
                        o_scan_ok     <= r_res_ok;
                        o_value_read  <= r_res_val;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/plc_fbs_checker.sv =====
// port level checks of the function block scan engine, bound to the top level
// depends on plc_fbs_pkg and plc_function_block_scan_top
module plc_fbs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [plc_fbs_pkg::IO_W-1:0]        o_output_bits,
    input logic                                o_scan_ok,
    input logic                                o_value_read
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // words taken in and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("request taken while another is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable({o_output_bits, o_scan_ok, o_value_read}))
        else $error("stalled result word changed");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_value_read |-> o_scan_ok)
        else $error("value reported on a failed request");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 2'd0)
        else $error("result word without a request");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind plc_function_block_scan_top plc_fbs_checker u_plc_fbs_checker (.*);
